@@ rtl/core/lps_pkg.sv @@
`default_nettype none

package lps_pkg;

   localparam int COORD_BITS = 12;
   localparam int DELTA_BITS = COORD_BITS + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-1:0]        mag_type;
   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic [COORD_BITS:0]          acc_type;

   typedef enum logic {
      REQ_START   = 1'b0,
      REQ_ADVANCE = 1'b1
   } req_kind_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_ACTIVE = 1'b1
   } line_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // start word accepted: latch endpoints
      logic step;   // advance word accepted on an active line
      logic emit;   // capture a point into the output register
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic start_last;   // incoming start word describes a zero-length line
      logic step_last;    // next advance reaches the end point
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/core/lps_if.sv @@
`default_nettype none

interface lps_req_if;
   logic                 valid;
   logic                 ready;
   lps_pkg::req_kind_type req_type;
   lps_pkg::coord_type   begin_x;
   lps_pkg::coord_type   begin_y;
   lps_pkg::coord_type   end_x;
   lps_pkg::coord_type   end_y;

   modport source (output valid, req_type, begin_x, begin_y, end_x, end_y, input ready);
   modport sink (input valid, req_type, begin_x, begin_y, end_x, end_y, output ready);
   modport monitor (input valid, ready, req_type, begin_x, begin_y, end_x, end_y);
endinterface

interface lps_rsp_if;
   logic               valid;
   logic               ready;
   lps_pkg::coord_type point_x;
   lps_pkg::coord_type point_y;
   logic               last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink (input valid, point_x, point_y, last_point, output ready);
   modport monitor (input valid, ready, point_x, point_y, last_point);
endinterface

`default_nettype wire

@@ rtl/core/lps_axis.sv @@
`default_nettype none

// One coordinate axis. Tracks |delta|*t / length as quotient and remainder,
// adding |delta| each step; since |delta| <= length one subtract suffices.
module lps_axis (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic               step,
   input  wire lps_pkg::coord_type begin_c,
   input  wire lps_pkg::coord_type end_c,
   input  wire lps_pkg::mag_type   length,
   output lps_pkg::mag_type        mag_new,
   output lps_pkg::coord_type      point_next
);

   lps_pkg::coord_type origin_ff, origin_in;
   lps_pkg::mag_type   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   lps_pkg::mag_type   quo_ff, quo_in;
   lps_pkg::mag_type   rem_ff, rem_in;

   lps_pkg::delta_type delta;
   lps_pkg::delta_type delta_abs;
   lps_pkg::acc_type   sum;
   logic               wrap;
   lps_pkg::mag_type   quo_next;
   lps_pkg::mag_type   rem_next;
   lps_pkg::coord_type offset;

   always_comb begin
      delta     = {end_c[lps_pkg::COORD_BITS-1], end_c}
                - {begin_c[lps_pkg::COORD_BITS-1], begin_c};
      delta_abs = delta[lps_pkg::DELTA_BITS-1] ? -delta : delta;
      mag_new   = delta_abs[lps_pkg::COORD_BITS-1:0];
   end

   always_comb begin
      sum      = {1'b0, rem_ff} + {1'b0, mag_ff};
      wrap     = sum >= {1'b0, length};
      rem_next = wrap ? lps_pkg::mag_type'(sum - {1'b0, length})
                      : sum[lps_pkg::COORD_BITS-1:0];
      quo_next = quo_ff + {{(lps_pkg::COORD_BITS-1){1'b0}}, wrap};
      // truncation toward zero: negate the magnitude quotient
      offset     = neg_ff ? -quo_next : quo_next;
      point_next = origin_ff + offset;
   end

   always_comb begin
      origin_in = origin_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (load) begin
         origin_in = begin_c;
         mag_in    = mag_new;
         neg_in    = delta[lps_pkg::DELTA_BITS-1];
         quo_in    = '0;
         rem_in    = '0;
      end else if (step) begin
         quo_in = quo_next;
         rem_in = rem_next;
      end
   end

   always_ff @(posedge clock) begin
      origin_ff <= origin_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/lps_datapath.sv @@
`default_nettype none

module lps_datapath (
   input  wire logic                clock,
   input  wire lps_pkg::dp_cmd_type cmd,
   input  wire lps_pkg::coord_type  begin_x,
   input  wire lps_pkg::coord_type  begin_y,
   input  wire lps_pkg::coord_type  end_x,
   input  wire lps_pkg::coord_type  end_y,
   output lps_pkg::dp_stat_type     stat,
   output lps_pkg::coord_type       point_x,
   output lps_pkg::coord_type       point_y,
   output logic                     last_point
);

   lps_pkg::mag_type   length_ff, length_in;
   lps_pkg::mag_type   step_ff, step_in;
   lps_pkg::coord_type point_x_ff, point_x_in;
   lps_pkg::coord_type point_y_ff, point_y_in;
   logic               last_ff, last_in;

   lps_pkg::mag_type   mag_x, mag_y;
   lps_pkg::coord_type next_x, next_y;
   lps_pkg::mag_type   length_new;
   lps_pkg::mag_type   step_next;

   lps_axis u_axis_x (
      .clock      (clock),
      .load       (cmd.load),
      .step       (cmd.step),
      .begin_c    (begin_x),
      .end_c      (end_x),
      .length     (length_ff),
      .mag_new    (mag_x),
      .point_next (next_x)
   );

   lps_axis u_axis_y (
      .clock      (clock),
      .load       (cmd.load),
      .step       (cmd.step),
      .begin_c    (begin_y),
      .end_c      (end_y),
      .length     (length_ff),
      .mag_new    (mag_y),
      .point_next (next_y)
   );

   always_comb begin
      length_new      = (mag_x > mag_y) ? mag_x : mag_y;
      step_next       = step_ff + {{(lps_pkg::COORD_BITS-1){1'b0}}, 1'b1};
      stat.start_last = length_new == '0;
      stat.step_last  = step_next == length_ff;
   end

   always_comb begin
      length_in  = length_ff;
      step_in    = step_ff;
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         length_in = length_new;
         step_in   = '0;
      end else if (cmd.step) begin
         step_in = step_next;
      end
      if (cmd.emit) begin
         point_x_in = cmd.load ? begin_x : next_x;
         point_y_in = cmd.load ? begin_y : next_y;
         last_in    = cmd.load ? stat.start_last : stat.step_last;
      end
   end

   always_ff @(posedge clock) begin
      length_ff  <= length_in;
      step_ff    <= step_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      last_ff    <= last_in;
   end

   assign point_x    = point_x_ff;
   assign point_y    = point_y_ff;
   assign last_point = last_ff;

endmodule

`default_nettype wire

@@ rtl/core/lps_ctrl.sv @@
`default_nettype none

module lps_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire lps_pkg::req_kind_type req_type,
   input  wire logic                  rsp_ready,
   input  wire lps_pkg::dp_stat_type  stat,
   output logic                       req_ready,
   output logic                       rsp_valid,
   output lps_pkg::dp_cmd_type        cmd
);

   lps_pkg::line_state_type state_ff, state_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    accept;

   // outputs; nothing is taken while reset is held
   always_comb begin
      req_ready = !reset && (!out_valid_ff || rsp_ready);
      rsp_valid = out_valid_ff;
      accept    = req_valid && req_ready;
      cmd.load  = accept && (req_type == lps_pkg::REQ_START);
      cmd.step  = accept && (req_type == lps_pkg::REQ_ADVANCE)
                  && (state_ff == lps_pkg::ST_ACTIVE);
      cmd.emit  = cmd.load || cmd.step;
      out_valid_in = cmd.emit || (out_valid_ff && !rsp_ready);
   end

   // next state; a start abandons any line in progress
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lps_pkg::ST_IDLE: begin
            if (cmd.load && !stat.start_last)
               state_in = lps_pkg::ST_ACTIVE;
         end
         lps_pkg::ST_ACTIVE: begin
            if (cmd.load)
               state_in = stat.start_last ? lps_pkg::ST_IDLE : lps_pkg::ST_ACTIVE;
            else if (cmd.step && stat.step_last)
               state_in = lps_pkg::ST_IDLE;
         end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lps_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/line_point_stepper_core.sv @@
// Line point stepper: emits the points of a straight line, at most one per word.
//
// req_chan (sink): req_type = start carries begin/end points and yields the
// begin point; req_type = advance yields the next point begin + delta*t/len,
// len = max(|dx|, |dy|), division truncating toward zero. An advance with no
// line in progress is taken and yields nothing. A start abandons any line.
// rsp_chan (source): point_x, point_y and last_point, set on the final point
// (and on the begin point of a zero-length line).
//
// Latency: a point appears on rsp_chan the cycle after its request word is
// taken. Throughput: one word per cycle unless stalled; each point costs one
// add and compare per axis in the quotient/remainder accumulators, no divider.
// The output register holds one word; while it is full and rsp_chan.ready is
// low, req_chan.ready is low, and no word is lost or repeated.
// Reset (synchronous, active high) empties the output register and leaves no
// line in progress; the block is ready as soon as reset is released.
`default_nettype none

module line_point_stepper_core (
   input  wire logic  clock,
   input  wire logic  reset,
   lps_req_if.sink    req_chan,
   lps_rsp_if.source  rsp_chan
);

   lps_pkg::dp_cmd_type  cmd;
   lps_pkg::dp_stat_type stat;

   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   lps_datapath u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .begin_x    (req_chan.begin_x),
      .begin_y    (req_chan.begin_y),
      .end_x      (req_chan.end_x),
      .end_y      (req_chan.end_y),
      .stat       (stat),
      .point_x    (rsp_chan.point_x),
      .point_y    (rsp_chan.point_y),
      .last_point (rsp_chan.last_point)
   );

endmodule

`default_nettype wire

@@ rtl/core/lps_checker.sv @@
`default_nettype none

module lps_checker (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire lps_pkg::req_kind_type req_type,
   input  wire lps_pkg::coord_type    begin_x,
   input  wire lps_pkg::coord_type    begin_y,
   input  wire lps_pkg::coord_type    end_x,
   input  wire lps_pkg::coord_type    end_y,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire lps_pkg::coord_type    point_x,
   input  wire lps_pkg::coord_type    point_y,
   input  wire logic                  last_point
);

   logic start_acc;
   logic zero_len;

   assign start_acc = req_valid && req_ready
                      && (req_type == lps_pkg::REQ_START);
   assign zero_len  = (begin_x == end_x) && (begin_y == end_y);

   // a stalled word stays presented
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // empty output register never blocks the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // a start yields its begin point in the next cycle
   a_start_point: assert property (@(posedge clock) disable iff (reset)
      start_acc |=> rsp_valid
                    && point_x == $past(begin_x)
                    && point_y == $past(begin_y))
      else $error("start did not yield begin point");

   // last flag on a start reflects a zero-length line
   a_start_last: assert property (@(posedge clock) disable iff (reset)
      start_acc |=> last_point == $past(zero_len))
      else $error("wrong last flag on start");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

bind line_point_stepper_core lps_checker u_lps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_type   (req_chan.req_type),
   .begin_x    (req_chan.begin_x),
   .begin_y    (req_chan.begin_y),
   .end_x      (req_chan.end_x),
   .end_y      (req_chan.end_y),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .point_x    (rsp_chan.point_x),
   .point_y    (rsp_chan.point_y),
   .last_point (rsp_chan.last_point)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 267;

   typedef struct {
      lps_pkg::coord_type x;
      lps_pkg::coord_type y;
      logic               last;
   } point_word_type;

   // Tracks the line in progress and the points still owed by the block.
   class point_tracker;
      lps_pkg::coord_type origin_x;
      lps_pkg::coord_type origin_y;
      int                 delta_x;
      int                 delta_y;
      int                 span;
      int                 step_idx;
      bit                 drawing;
      point_word_type     pending_points[$];
      int                 errors;
      int                 starts;
      int                 abandoned;
      int                 advances;
      int                 idle_advances;
      int                 points_checked;
      int                 last_points;

      function int magnitude(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void note_word(lps_pkg::req_kind_type kind,
                              lps_pkg::coord_type bx, lps_pkg::coord_type by,
                              lps_pkg::coord_type ex, lps_pkg::coord_type ey);
         point_word_type pt;
         int             px;
         int             py;
         if (kind == lps_pkg::REQ_START) begin
            if (drawing)
               abandoned++;
            starts++;
            origin_x = bx;
            origin_y = by;
            delta_x  = int'(ex) - int'(bx);
            delta_y  = int'(ey) - int'(by);
            span     = (magnitude(delta_x) > magnitude(delta_y)) ?
                       magnitude(delta_x) : magnitude(delta_y);
            step_idx = 0;
            drawing  = (span != 0);
            pt.x     = bx;
            pt.y     = by;
            pt.last  = !drawing;
            pending_points.push_back(pt);
         end else if (!drawing) begin
            idle_advances++;
         end else begin
            advances++;
            step_idx++;
            // SV integer division truncates toward zero
            px      = int'(origin_x) + (delta_x * step_idx) / span;
            py      = int'(origin_y) + (delta_y * step_idx) / span;
            pt.x    = lps_pkg::coord_type'(px);
            pt.y    = lps_pkg::coord_type'(py);
            pt.last = (step_idx >= span);
            if (pt.last)
               drawing = 0;
            pending_points.push_back(pt);
         end
      endfunction

      function void check_point(lps_pkg::coord_type x, lps_pkg::coord_type y, logic last);
         point_word_type want;
         if (pending_points.size() == 0) begin
            errors++;
            $display("%0t: point (%0d,%0d) last=%0b arrived with none expected",
                     $time, x, y, last);
            return;
         end
         want = pending_points.pop_front();
         points_checked++;
         if (last === 1'b1)
            last_points++;
         if (x !== want.x) begin
            errors++;
            $display("%0t: point_x expected %0d actual %0d", $time, want.x, x);
         end
         if (y !== want.y) begin
            errors++;
            $display("%0t: point_y expected %0d actual %0d", $time, want.y, y);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last_point expected %0b actual %0b", $time, want.last, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   gap_pct   = 0;
   int   stall_pct = 0;
   int   cycle_count = 0;
   point_tracker tracker;

   lps_req_if req_chan ();
   lps_rsp_if rsp_chan ();

   line_point_stepper_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            tracker.note_word(req_chan.req_type, req_chan.begin_x, req_chan.begin_y,
                              req_chan.end_x, req_chan.end_y);
         if (rsp_chan.valid && rsp_chan.ready)
            tracker.check_point(rsp_chan.point_x, rsp_chan.point_y, rsp_chan.last_point);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic lps_pkg::coord_type clamp_coord(int v);
      if (v > 2047)
         return lps_pkg::coord_type'(2047);
      if (v < -2048)
         return lps_pkg::coord_type'(-2048);
      return lps_pkg::coord_type'(v);
   endfunction

   // Called just after a falling edge; returns just after the falling edge
   // that follows acceptance, with valid still high.
   task automatic send_word(input lps_pkg::req_kind_type kind,
                            input lps_pkg::coord_type bx, input lps_pkg::coord_type by,
                            input lps_pkg::coord_type ex, input lps_pkg::coord_type ey);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.begin_x  <= bx;
      req_chan.begin_y  <= by;
      req_chan.end_x    <= ex;
      req_chan.end_y    <= ey;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_advance();
      send_word(lps_pkg::REQ_ADVANCE,
                lps_pkg::coord_type'($urandom), lps_pkg::coord_type'($urandom),
                lps_pkg::coord_type'($urandom), lps_pkg::coord_type'($urandom));
   endtask

   // Hold off the sender until every owed point has come back.
   task automatic drain_points();
      req_chan.valid <= 1'b0;
      while (tracker.pending_points.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic run_random(input int goal);
      lps_pkg::coord_type bx;
      lps_pkg::coord_type by;
      lps_pkg::coord_type ex;
      lps_pkg::coord_type ey;
      int                 dx;
      int                 dy;
      int                 span;
      int                 count;
      int                 shape;
      int                 pick;
      while (tracker.starts + tracker.advances < goal) begin
         shape = $urandom_range(99);
         bx    = lps_pkg::coord_type'($urandom);
         by    = lps_pkg::coord_type'($urandom);
         if (shape < 8) begin
            // noise: stray advances and starts with unrelated content
            send_word(lps_pkg::req_kind_type'($urandom_range(1)), bx, by,
                      lps_pkg::coord_type'($urandom), lps_pkg::coord_type'($urandom));
            continue;
         end
         if (shape < 14) begin
            ex = lps_pkg::coord_type'($urandom);
            ey = lps_pkg::coord_type'($urandom);
         end else begin
            if (shape < 17) begin
               dx = int'($urandom_range(400)) - 200;
               dy = int'($urandom_range(400)) - 200;
            end else begin
               dx = int'($urandom_range(32)) - 16;
               dy = int'($urandom_range(32)) - 16;
            end
            ex = clamp_coord(int'(bx) + dx);
            ey = clamp_coord(int'(by) + dy);
         end
         dx   = tracker.magnitude(int'(ex) - int'(bx));
         dy   = tracker.magnitude(int'(ey) - int'(by));
         span = (dx > dy) ? dx : dy;
         send_word(lps_pkg::REQ_START, bx, by, ex, ey);
         if (shape < 14) begin
            count = $urandom_range(30);
         end else begin
            pick = $urandom_range(9);
            if (pick < 7)
               count = span;
            else if (pick == 7)
               count = $urandom_range(span);
            else
               count = span + $urandom_range(3, 1);
         end
         repeat (count) send_advance();
         if ($urandom_range(49) == 0)
            drain_points();
      end
   endtask

   initial begin
      tracker           = new();
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.req_type = lps_pkg::REQ_START;
      req_chan.begin_x  = '0;
      req_chan.begin_y  = '0;
      req_chan.end_x    = '0;
      req_chan.end_y    = '0;
      rsp_chan.ready    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_pct   = 20;
      stall_pct = 46;
      // directed: idle advance, zero-length lines, extreme spans, abandonment,
      // overrun past the end point, negative steps truncating toward zero
      send_advance();
      send_word(lps_pkg::REQ_START, 12'sd0, 12'sd0, 12'sd0, 12'sd0);
      send_advance();
      send_word(lps_pkg::REQ_START, 12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047);
      send_word(lps_pkg::REQ_START, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
      repeat (2) send_advance();
      send_word(lps_pkg::REQ_START, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
      send_advance();
      send_word(lps_pkg::REQ_START, -12'sd2048, 12'sd2047, 12'sd2047, 12'sd2047);
      send_advance();
      send_word(lps_pkg::REQ_START, 12'sd1, 12'sd1, -12'sd2, 12'sd3);
      repeat (4) send_advance();
      send_word(lps_pkg::REQ_START, 12'sd0, 12'sd0, -12'sd2, 12'sd5);
      repeat (5) send_advance();
      drain_points();

      run_random(PHASE_WORDS);
      drain_points();
      gap_pct   = 46;
      stall_pct = 20;
      run_random(2 * PHASE_WORDS);
      drain_points();
      gap_pct   = 0;
      stall_pct = 0;
      run_random(3 * PHASE_WORDS);
      drain_points();
      repeat (10) @(posedge clock);

      $display("Covered %0d line starts (%0d abandoning a line), %0d advances, %0d idle advances.",
               tracker.starts, tracker.abandoned, tracker.advances, tracker.idle_advances);
      $display("Compared %0d points, %0d of them line ends; %0d mismatches.",
               tracker.points_checked, tracker.last_points, tracker.errors);
      if (tracker.errors == 0 && tracker.pending_points.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lps_pkg.sv
rtl/core/lps_if.sv
rtl/core/lps_axis.sv
rtl/core/lps_datapath.sv
rtl/core/lps_ctrl.sv
rtl/core/line_point_stepper_core.sv
rtl/core/lps_checker.sv
tb/tb.sv
